// File: hdl/modular_number_theory_unit_top_macros.svh
// Assertion macros for the modular number-theory unit checker.
// Depends on nothing; included by the checker file only.
`ifndef MODULAR_NUMBER_THEORY_UNIT_TOP_MACROS_SVH
`define MODULAR_NUMBER_THEORY_UNIT_TOP_MACROS_SVH
// Check a property at every rising edge outside reset.
`define MNTU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition leads to another in the next cycle.
`define MNTU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`endif

// File: hdl/mntu_pkg.sv
// Shared constants, codes and interface structs of the modular number-theory unit.
// Depends on nothing; used by every module of the block.
package mntu_pkg;

  localparam int W       = 32;
  localparam int FIELD_W = 32;
  localparam int RES_W   = 64;
  localparam int CW      = W + 2;
  localparam int CNT_W   = $clog2(W);

  typedef enum logic [1:0] {
    ACT_GCD = 2'd0,
    ACT_LCM = 2'd1,
    ACT_POW = 2'd2,
    ACT_INV = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EUC,
    S_EUC_W,
    S_LCM_DIV,
    S_LCM_MUL,
    S_PW_RED,
    S_PW_RED_W,
    S_PW_BIT,
    S_PW_MUL,
    S_PW_SQ,
    S_PW_SQ_W,
    S_INV_ABS,
    S_INV_MOD,
    S_INV_OUT
  } state_t;

  typedef struct packed {
    logic                 done;
    logic [W-1:0]         quo;
    logic [W-1:0]         rem;
    logic signed [CW-1:0] prod;
  } div_res_t;

  typedef struct packed {
    logic start;
    logic reduce;
  } mm_cmd_t;

  typedef struct packed {
    logic           done;
    logic [2*W-1:0] value;
  } mm_res_t;

endpackage

// File: hdl/mntu_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Also accumulates quotient times a signed coefficient by Horner steps.
// Depends on mntu_pkg.
module mntu_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mntu_pkg::W-1:0]         dividend,
  input  logic [mntu_pkg::W-1:0]         divisor,
  input  logic signed [mntu_pkg::CW-1:0] coef,
  output mntu_pkg::div_res_t             res
);

  logic                           busy;
  logic                           done;
  logic [mntu_pkg::CNT_W-1:0]     cnt;
  logic [mntu_pkg::W-1:0]         n;
  logic [mntu_pkg::W-1:0]         d;
  logic [mntu_pkg::W-1:0]         r;
  logic signed [mntu_pkg::CW-1:0] c;
  logic signed [mntu_pkg::CW-1:0] p;

  logic [mntu_pkg::W:0]           rsh;
  logic [mntu_pkg::W:0]           diff;
  logic                           ge;
  logic [mntu_pkg::W-1:0]         r_next;
  logic signed [mntu_pkg::CW-1:0] p_next;

  always_comb begin
    rsh    = {r, n[mntu_pkg::W-1]};
    ge     = (rsh >= {1'b0, d});
    diff   = rsh - {1'b0, d};
    r_next = ge ? diff[mntu_pkg::W-1:0] : rsh[mntu_pkg::W-1:0];
    p_next = (p <<< 1) + (ge ? c : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= dividend;
      d   <= divisor;
      c   <= coef;
      r   <= '0;
      p   <= '0;
      cnt <= mntu_pkg::CNT_W'(mntu_pkg::W - 1);
    end else if (busy) begin
      n   <= {n[mntu_pkg::W-2:0], ge};
      r   <= r_next;
      p   <= p_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign res.done = done;
  assign res.quo  = n;
  assign res.rem  = r;
  assign res.prod = p;

endmodule

// File: hdl/mntu_mulmod.sv
// Bit-serial multiplier, MSB first: plain 2W-bit product or interleaved
// modular product with the operand below the modulus. Depends on mntu_pkg.
module mntu_mulmod (
  input  logic                   clk,
  input  logic                   rst,
  input  mntu_pkg::mm_cmd_t      cmd,
  input  logic [mntu_pkg::W-1:0] mul_y,
  input  logic [mntu_pkg::W-1:0] mul_x,
  input  logic [mntu_pkg::W-1:0] md,
  output mntu_pkg::mm_res_t      res
);

  logic                       busy;
  logic                       done;
  logic                       red;
  logic [mntu_pkg::CNT_W-1:0] cnt;
  logic [mntu_pkg::W-1:0]     ys;
  logic [mntu_pkg::W-1:0]     xs;
  logic [mntu_pkg::W-1:0]     ms;
  logic [2*mntu_pkg::W-1:0]   acc;

  logic [mntu_pkg::W-1:0]     addend;
  logic [mntu_pkg::W+1:0]     t;
  logic [mntu_pkg::W+1:0]     m1;
  logic [mntu_pkg::W+1:0]     m2;
  logic [mntu_pkg::W+1:0]     rmod;
  logic [2*mntu_pkg::W-1:0]   plain;
  logic [2*mntu_pkg::W-1:0]   acc_next;

  always_comb begin
    addend = ys[mntu_pkg::W-1] ? xs : '0;
    t      = {1'b0, acc[mntu_pkg::W-1:0], 1'b0} + {2'b00, addend};
    m1     = {2'b00, ms};
    m2     = {1'b0, ms, 1'b0};
    if (t >= m2) begin
      rmod = t - m2;
    end else if (t >= m1) begin
      rmod = t - m1;
    end else begin
      rmod = t;
    end
    plain    = {acc[2*mntu_pkg::W-2:0], 1'b0} + {{mntu_pkg::W{1'b0}}, addend};
    acc_next = red ? {{mntu_pkg::W{1'b0}}, rmod[mntu_pkg::W-1:0]} : plain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      red <= cmd.reduce;
      ys  <= mul_y;
      xs  <= mul_x;
      ms  <= md;
      acc <= '0;
      cnt <= mntu_pkg::CNT_W'(mntu_pkg::W - 1);
    end else if (busy) begin
      ys  <= {ys[mntu_pkg::W-2:0], 1'b0};
      acc <= acc_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign res.done  = done;
  assign res.value = acc;

endmodule

// File: hdl/modular_number_theory_unit_top.sv
// Modular number-theory unit: gcd, lcm, modular power and modular inverse.
// Depends on mntu_pkg, mntu_div and mntu_mulmod.
//
// An item is taken when start is high and busy is low; its single result
// appears on result and error for one cycle with done high, and must be
// taken then. Operand errors (lcm of two zeros, zero modulus) and a zero
// exponent answer in the cycle after the item is taken. Otherwise the work
// is done by two bit-serial units (W = 32): the divider, one use per Euclid
// step, and the modular multiplier. gcd and inverse run the Euclid steps on
// 32-bit operands, the inverse then takes the sign off, reduces and outputs
// its coefficient; lcm adds a division and a plain multiplication to its gcd;
// modular power reduces the base, then per exponent bit multiplies if the bit
// is set and squares while bits remain. One item is in work at a time.
module modular_number_theory_unit_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [mntu_pkg::FIELD_W-1:0] operand_a,
  input  logic [mntu_pkg::FIELD_W-1:0] operand_b,
  input  logic [mntu_pkg::FIELD_W-1:0] modulus,
  output logic                         done,
  output logic [mntu_pkg::RES_W-1:0]   result,
  output logic                         error
);

  mntu_pkg::state_t state;
  mntu_pkg::state_t state_next;
  mntu_pkg::act_t   act;
  mntu_pkg::act_t   act_in;

  logic [mntu_pkg::W-1:0]         a_in;
  logic [mntu_pkg::W-1:0]         b_in;
  logic [mntu_pkg::W-1:0]         m_in;

  logic [mntu_pkg::W-1:0]         x;
  logic [mntu_pkg::W-1:0]         y;
  logic [mntu_pkg::W-1:0]         opa;
  logic [mntu_pkg::W-1:0]         opb;
  logic [mntu_pkg::W-1:0]         md;
  logic [mntu_pkg::W-1:0]         acc;
  logic signed [mntu_pkg::CW-1:0] c0;
  logic signed [mntu_pkg::CW-1:0] c1;
  logic                           neg;

  logic                           div_start;
  logic [mntu_pkg::W-1:0]         div_n;
  logic [mntu_pkg::W-1:0]         div_d;
  logic signed [mntu_pkg::CW-1:0] div_c;
  mntu_pkg::div_res_t             div_res;

  mntu_pkg::mm_cmd_t              mm_cmd;
  logic [mntu_pkg::W-1:0]         mm_y;
  logic [mntu_pkg::W-1:0]         mm_x;
  mntu_pkg::mm_res_t              mm_res;

  logic                           fin;
  logic                           fin_err;
  logic [2*mntu_pkg::W-1:0]       fin_val;
  logic [mntu_pkg::W-1:0]         inv_val;

  assign a_in   = operand_a[mntu_pkg::W-1:0];
  assign b_in   = operand_b[mntu_pkg::W-1:0];
  assign m_in   = modulus[mntu_pkg::W-1:0];
  assign act_in = mntu_pkg::act_t'(action);
  assign busy   = (state != mntu_pkg::S_IDLE);

  assign inv_val = (neg && (c0 != '0)) ? (md - c0[mntu_pkg::W-1:0])
                                       : c0[mntu_pkg::W-1:0];

  mntu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .coef     (div_c),
    .res      (div_res)
  );

  mntu_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mm_cmd),
    .mul_y (mm_y),
    .mul_x (mm_x),
    .md    (md),
    .res   (mm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mntu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    div_n         = x;
    div_d         = y;
    div_c         = c1;
    mm_cmd.start  = 1'b0;
    mm_cmd.reduce = 1'b1;
    mm_y          = acc;
    mm_x          = x;
    fin           = 1'b0;
    fin_err       = 1'b0;
    fin_val       = '0;
    unique case (state)
      mntu_pkg::S_IDLE: begin
        if (start) begin
          unique case (act_in)
            mntu_pkg::ACT_GCD: begin
              state_next = mntu_pkg::S_EUC;
            end
            mntu_pkg::ACT_LCM: begin
              if ((a_in == '0) && (b_in == '0)) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else begin
                state_next = mntu_pkg::S_EUC;
              end
            end
            mntu_pkg::ACT_POW: begin
              if (m_in == '0) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else if (b_in == '0) begin
                fin     = 1'b1;
                fin_val = (2*mntu_pkg::W)'(1);
              end else begin
                state_next = mntu_pkg::S_PW_RED;
              end
            end
            mntu_pkg::ACT_INV: begin
              if (m_in == '0) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else begin
                state_next = mntu_pkg::S_EUC;
              end
            end
          endcase
        end
      end
      mntu_pkg::S_EUC: begin
        if (y == '0) begin
          unique case (act)
            mntu_pkg::ACT_GCD: begin
              fin        = 1'b1;
              fin_val    = {{mntu_pkg::W{1'b0}}, x};
              state_next = mntu_pkg::S_IDLE;
            end
            mntu_pkg::ACT_LCM: begin
              div_start  = 1'b1;
              div_n      = opa;
              div_d      = x;
              div_c      = '0;
              state_next = mntu_pkg::S_LCM_DIV;
            end
            default: begin
              state_next = mntu_pkg::S_INV_ABS;
            end
          endcase
        end else begin
          div_start  = 1'b1;
          state_next = mntu_pkg::S_EUC_W;
        end
      end
      mntu_pkg::S_EUC_W: begin
        if (div_res.done) begin
          state_next = mntu_pkg::S_EUC;
        end
      end
      mntu_pkg::S_LCM_DIV: begin
        if (div_res.done) begin
          mm_cmd.start  = 1'b1;
          mm_cmd.reduce = 1'b0;
          mm_y          = opb;
          mm_x          = div_res.quo;
          state_next    = mntu_pkg::S_LCM_MUL;
        end
      end
      mntu_pkg::S_LCM_MUL: begin
        if (mm_res.done) begin
          fin        = 1'b1;
          fin_val    = mm_res.value;
          state_next = mntu_pkg::S_IDLE;
        end
      end
      mntu_pkg::S_PW_RED: begin
        mm_cmd.start = 1'b1;
        mm_y         = opa;
        mm_x         = mntu_pkg::W'(1);
        state_next   = mntu_pkg::S_PW_RED_W;
      end
      mntu_pkg::S_PW_RED_W: begin
        if (mm_res.done) begin
          state_next = mntu_pkg::S_PW_BIT;
        end
      end
      mntu_pkg::S_PW_BIT: begin
        if (y == '0) begin
          fin        = 1'b1;
          fin_val    = {{mntu_pkg::W{1'b0}}, acc};
          state_next = mntu_pkg::S_IDLE;
        end else if (y[0]) begin
          mm_cmd.start = 1'b1;
          mm_y         = acc;
          mm_x         = x;
          state_next   = mntu_pkg::S_PW_MUL;
        end else begin
          state_next = mntu_pkg::S_PW_SQ;
        end
      end
      mntu_pkg::S_PW_MUL: begin
        if (mm_res.done) begin
          state_next = mntu_pkg::S_PW_SQ;
        end
      end
      mntu_pkg::S_PW_SQ: begin
        if (y[mntu_pkg::W-1:1] == '0) begin
          state_next = mntu_pkg::S_PW_BIT;
        end else begin
          mm_cmd.start = 1'b1;
          mm_y         = x;
          mm_x         = x;
          state_next   = mntu_pkg::S_PW_SQ_W;
        end
      end
      mntu_pkg::S_PW_SQ_W: begin
        if (mm_res.done) begin
          state_next = mntu_pkg::S_PW_BIT;
        end
      end
      mntu_pkg::S_INV_ABS: begin
        state_next = mntu_pkg::S_INV_MOD;
      end
      mntu_pkg::S_INV_MOD: begin
        state_next = mntu_pkg::S_INV_OUT;
      end
      mntu_pkg::S_INV_OUT: begin
        fin        = 1'b1;
        fin_val    = {{mntu_pkg::W{1'b0}}, inv_val};
        state_next = mntu_pkg::S_IDLE;
      end
      default: begin
        state_next = mntu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mntu_pkg::S_IDLE: begin
        if (start) begin
          act <= act_in;
          opa <= a_in;
          opb <= b_in;
          md  <= m_in;
          x   <= a_in;
          y   <= (act_in == mntu_pkg::ACT_INV) ? m_in : b_in;
          c0  <= mntu_pkg::CW'(1);
          c1  <= '0;
          acc <= (m_in == mntu_pkg::W'(1)) ? '0 : mntu_pkg::W'(1);
        end
      end
      mntu_pkg::S_EUC_W: begin
        if (div_res.done) begin
          x  <= y;
          y  <= div_res.rem;
          c0 <= c1;
          c1 <= c0 - div_res.prod;
        end
      end
      mntu_pkg::S_PW_RED_W, mntu_pkg::S_PW_SQ_W: begin
        if (mm_res.done) begin
          x <= mm_res.value[mntu_pkg::W-1:0];
        end
      end
      mntu_pkg::S_PW_MUL: begin
        if (mm_res.done) begin
          acc <= mm_res.value[mntu_pkg::W-1:0];
        end
      end
      mntu_pkg::S_PW_SQ: begin
        y <= y >> 1;
      end
      mntu_pkg::S_INV_ABS: begin
        neg <= c0[mntu_pkg::CW-1];
        c0  <= c0[mntu_pkg::CW-1] ? -c0 : c0;
      end
      mntu_pkg::S_INV_MOD: begin
        if ($unsigned(c0) >= mntu_pkg::CW'(md)) begin
          c0 <= c0 - $signed(mntu_pkg::CW'(md));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result <= mntu_pkg::RES_W'(fin_val);
      error  <= fin_err;
    end
  end

endmodule

// File: hdl/mntu_checker.sv
// Port-level checks of the modular number-theory unit, bound to the top level.
// Depends on mntu_pkg and modular_number_theory_unit_top_macros.svh.
`include "modular_number_theory_unit_top_macros.svh"

module mntu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   action,
  input logic [mntu_pkg::FIELD_W-1:0] operand_a,
  input logic [mntu_pkg::FIELD_W-1:0] operand_b,
  input logic [mntu_pkg::FIELD_W-1:0] modulus,
  input logic                         done,
  input logic [mntu_pkg::RES_W-1:0]   result,
  input logic                         error
);

  logic take;
  logic lcm_zeros;
  logic mod_ok;

  assign take      = start && !busy;
  assign lcm_zeros = (action == mntu_pkg::ACT_LCM)
                     && (operand_a[mntu_pkg::W-1:0] == '0)
                     && (operand_b[mntu_pkg::W-1:0] == '0);
  assign mod_ok    = ((action == mntu_pkg::ACT_POW) || (action == mntu_pkg::ACT_INV))
                     && (modulus[mntu_pkg::W-1:0] != '0);

  `MNTU_ASSERT(a_err_zero, clk, rst, (done && error) |-> (result == '0), "error item with nonzero result")
  `MNTU_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result shown while busy")
  `MNTU_ASSERT_NEXT(a_take_moves, clk, rst, take, (busy || done), "item taken but unit stalled")
  `MNTU_ASSERT_NEXT(a_lcm_zero, clk, rst, (take && lcm_zeros), (done && error), "lcm of zeros not flagged")
  `MNTU_ASSERT_NEXT(a_mod_ok, clk, rst, (take && mod_ok), !(done && error), "valid modulus flagged")

endmodule

bind modular_number_theory_unit_top mntu_checker u_mntu_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .action    (action),
  .operand_a (operand_a),
  .operand_b (operand_b),
  .modulus   (modulus),
  .done      (done),
  .result    (result),
  .error     (error)
);
